>>> rtl/rse_pkg.sv
package rse_pkg;

  localparam int FREQ_W      = 13;
  localparam int CUM_W       = 12;
  localparam int CHUNK_W     = 8;
  localparam int STATE_W     = 32;
  localparam int MAX_RENORM  = 2;
  localparam int FLUSH_WORDS = 4;

  localparam int PROB_BITS_DEF   = 12;
  localparam int OUT_BITS_DEF    = 8;
  localparam int RENORM_LOG2_DEF = 12;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [CUM_W-1:0]  cum;
    logic              last_symbol;
  } in_word_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk;
    logic               last_chunk;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RENORM,
    ST_DIV,
    ST_CODE,
    ST_FLUSH
  } rse_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic renorm_emit;
    logic div_start;
    logic div_step;
    logic code;
    logic flush_emit;
  } rse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_freq_zero;
    logic in_last;
    logic last_sym;
    logic renorm_go;
    logic div_last;
    logic flush_end;
    logic out_free;
  } rse_sts_t;

endpackage

>>> rtl/rse_ctrl.sv
module rse_ctrl
  import rse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rse_sts_t sts,
  output rse_cmd_t cmd
);

  rse_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!sts.in_freq_zero) begin
            state_nxt = ST_RENORM;
          end else if (sts.in_last) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_RENORM: begin
        if (!sts.renorm_go) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_CODE;
        end
      end
      ST_CODE: begin
        state_nxt = sts.last_sym ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (sts.out_free && sts.flush_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RENORM: begin
        cmd.renorm_emit = sts.renorm_go && sts.out_free;
        cmd.div_start   = !sts.renorm_go;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_CODE: begin
        cmd.code = 1'b1;
      end
      ST_FLUSH: begin
        cmd.flush_emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/rse_dpath.sv
module rse_dpath
  import rse_pkg::*;
#(
  parameter int PROB_BITS   = PROB_BITS_DEF,
  parameter int OUT_BITS    = OUT_BITS_DEF,
  parameter int RENORM_LOG2 = RENORM_LOG2_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  logic      out_ready,
  output logic      out_valid,
  output out_word_t out_word,
  input  rse_cmd_t  cmd,
  output rse_sts_t  sts
);

  localparam int DIVC_W = $clog2(STATE_W);
  localparam int BOUND_SH = RENORM_LOG2 + OUT_BITS;
  localparam logic [STATE_W-1:0] RESET_VAL =
    STATE_W'(64'd1 << (RENORM_LOG2 + PROB_BITS));
  localparam logic [STATE_W-1:0] CHUNK_MASK = STATE_W'((64'd1 << OUT_BITS) - 64'd1);

  logic [STATE_W-1:0] x_r, x_nxt;
  logic [FREQ_W-1:0]  freq_r;
  logic [CUM_W-1:0]   cum_r;
  logic               last_r;
  logic [FREQ_W-1:0]  rem_r, rem_nxt;
  logic [DIVC_W-1:0]  divc_r;
  logic [1:0]         rcnt_r;
  logic [1:0]         fcnt_r;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r;

  logic [63:0]        bound;
  logic               ge_bound;
  logic [FREQ_W:0]    trial;
  logic               qbit;
  logic [STATE_W-1:0] masked;
  logic               emit;

  assign bound    = 64'(freq_r) << BOUND_SH;
  assign ge_bound = 64'(x_r) >= bound;
  assign trial    = {rem_r, x_r[STATE_W-1]};
  assign qbit     = trial >= {1'b0, freq_r};
  assign masked   = x_r & CHUNK_MASK;
  assign emit     = cmd.renorm_emit || cmd.flush_emit;

  // restoring divider uses x_r as the quotient shift register
  always_comb begin
    x_nxt   = x_r;
    rem_nxt = rem_r;
    if (cmd.renorm_emit) begin
      x_nxt = x_r >> OUT_BITS;
    end else if (cmd.div_start) begin
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      x_nxt   = {x_r[STATE_W-2:0], qbit};
      rem_nxt = qbit ? FREQ_W'(trial - {1'b0, freq_r}) : trial[FREQ_W-1:0];
    end else if (cmd.code) begin
      x_nxt = (x_r << PROB_BITS) + STATE_W'(rem_r) + STATE_W'(cum_r);
    end else if (cmd.flush_emit) begin
      x_nxt = (fcnt_r == 2'(FLUSH_WORDS - 1)) ? RESET_VAL : (x_r >> OUT_BITS);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= RESET_VAL;
      out_valid_r <= 1'b0;
      rcnt_r      <= '0;
      fcnt_r      <= '0;
      divc_r      <= '0;
    end else begin
      x_r         <= x_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.load) begin
        rcnt_r <= '0;
        fcnt_r <= '0;
      end
      if (cmd.renorm_emit) begin
        rcnt_r <= rcnt_r + 2'd1;
      end
      if (cmd.flush_emit) begin
        fcnt_r <= fcnt_r + 2'd1;
      end
      if (cmd.div_start) begin
        divc_r <= '0;
      end else if (cmd.div_step) begin
        divc_r <= divc_r + DIVC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (cmd.load) begin
      freq_r <= in_word.freq;
      cum_r  <= in_word.cum;
      last_r <= in_word.last_symbol;
    end
    if (emit) begin
      out_word_r.chunk      <= masked[CHUNK_W-1:0];
      out_word_r.last_chunk <= cmd.flush_emit && (fcnt_r == 2'(FLUSH_WORDS - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign sts.in_freq_zero = (in_word.freq == '0);
  assign sts.in_last      = in_word.last_symbol;
  assign sts.last_sym     = last_r;
  assign sts.renorm_go    = ge_bound && (rcnt_r != 2'(MAX_RENORM));
  assign sts.div_last     = (divc_r == DIVC_W'(STATE_W - 1));
  assign sts.flush_end    = (fcnt_r == 2'(FLUSH_WORDS - 1));
  assign sts.out_free     = !out_valid_r || out_ready;

endmodule

>>> rtl/rans_stream_encoder.sv
// rANS encoder with a single 32-bit coder state
// input channel: one word per symbol (freq, cum, last_symbol); symbol lookup is done upstream
// result channel: one word per emitted chunk, last_chunk marks the end of a stream flush
// per symbol: 0..2 renormalization chunks, while state >= freq << (renorm+out)
// the coding step is a restoring divider, one quotient bit per cycle,
// followed by a code step that forms (q << prob_bits) + r + cum
// a last symbol then sends four flush chunks, low bits first, and reloads the reset state
// a zero frequency skips renormalization and coding (the flush still runs if flagged)
// in_ready is high only between symbols; results sit in one output register, so a new
// symbol is taken while the previous chunk still waits for the receiver
// when out_ready is low the chunk holds and the engine waits before its next chunk
// reset (synchronous, active low) loads the state with 2^(renorm_log2 + prob_bits)
// and empties the output register
module rans_stream_encoder
  import rse_pkg::*;
#(
  parameter int PROB_BITS   = PROB_BITS_DEF,
  parameter int OUT_BITS    = OUT_BITS_DEF,
  parameter int RENORM_LOG2 = RENORM_LOG2_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  rse_cmd_t cmd;
  rse_sts_t sts;

  // sequencer: idle, renormalize, divide, code, flush
  rse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // coder state, divider and output register
  rse_dpath #(
    .PROB_BITS   (PROB_BITS),
    .OUT_BITS    (OUT_BITS),
    .RENORM_LOG2 (RENORM_LOG2)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/rse_checker.sv
module rse_checker
  import rse_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // a symbol that needs coding or flushing keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && ((in_word.freq != '0) || in_word.last_symbol) |=> !in_ready)
    else $error("input taken again right after a working symbol");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a symbol taken while the output is empty produces no chunk in the cycle after it is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("chunk produced in the cycle after a symbol was taken");

endmodule

bind rans_stream_encoder rse_checker u_rse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

>>> sim/tb_rans_stream_encoder.sv
module tb_rans_stream_encoder
  import rse_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // coder state after reset and between streams
  localparam logic [63:0] STATE_INIT =
    (64'd1 << (RENORM_LOG2_DEF + PROB_BITS_DEF)) & 64'hFFFF_FFFF;
  localparam logic [63:0] CHUNK_MASK = (64'd1 << OUT_BITS_DEF) - 64'd1;
  localparam int RANDOM_SYMBOLS = 210;
  // worst case per symbol: the divider loop, six words under long stalls, a sender gap
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_CYCLES = 64;

  // mirror of the coder, holds the chunk words still owed by the block
  class rans_scoreboard;
    logic [31:0] coder_state;
    out_word_t   chunk_q[$];
    int          errors;

    function new();
      coder_state = STATE_INIT[31:0];
      errors = 0;
    endfunction

    // encode one accepted symbol word, queue the chunks it must produce
    function void note_symbol(in_word_t w);
      logic [63:0] x;
      logic [63:0] bound;
      logic [63:0] quo;
      logic [63:0] rem;
      out_word_t   c;
      int          renorms;
      x = {32'd0, coder_state};
      if (w.freq != '0) begin
        bound = 64'(w.freq) << (RENORM_LOG2_DEF + OUT_BITS_DEF);
        renorms = 0;
        while (x >= bound && renorms < MAX_RENORM) begin
          c.chunk = CHUNK_W'(x & CHUNK_MASK);
          c.last_chunk = 1'b0;
          chunk_q.push_back(c);
          x = x >> OUT_BITS_DEF;
          renorms++;
        end
        quo = x / 64'(w.freq);
        rem = x % 64'(w.freq);
        x = ((quo << PROB_BITS_DEF) + rem + 64'(w.cum)) & 64'hFFFF_FFFF;
      end
      if (w.last_symbol) begin
        for (int i = 0; i < FLUSH_WORDS; i++) begin
          c.chunk = CHUNK_W'(x & CHUNK_MASK);
          c.last_chunk = (i == FLUSH_WORDS - 1);
          chunk_q.push_back(c);
          x = x >> OUT_BITS_DEF;
        end
        x = STATE_INIT;
      end
      coder_state = x[31:0];
    endfunction

    function void check_chunk(out_word_t got);
      out_word_t want;
      if (chunk_q.size() == 0) begin
        $display("%0t: unexpected word chunk=%02h last_chunk=%0b",
                 $realtime, got.chunk, got.last_chunk);
        errors++;
        return;
      end
      want = chunk_q.pop_front();
      if (got.chunk !== want.chunk) begin
        $display("%0t: chunk mismatch expected %02h actual %02h",
                 $realtime, want.chunk, got.chunk);
        errors++;
      end
      if (got.last_chunk !== want.last_chunk) begin
        $display("%0t: last_chunk mismatch expected %0b actual %0b",
                 $realtime, want.last_chunk, got.last_chunk);
        errors++;
      end
    endfunction

    function int pending();
      return chunk_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  rans_scoreboard sb = new();
  int cycle_count = 0;

  rans_stream_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input monitor: every accepted symbol word feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_symbol(in_word);
  end

  // output monitor: every accepted chunk word is checked in order
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_chunk(out_word);
  end

  // receiver back-pressure: the mode is drawn anew at random each time stall_phase wraps
  // mode 0 always ready, mode 1 coin flip, mode 2 held runs of random length
  int stall_mode = 0;
  int stall_phase = 0;
  int stall_hold = 0;
  always @(negedge clk) begin
    if (stall_phase == 0) stall_mode <= $urandom_range(0, 2);
    stall_phase <= (stall_phase + 1) % 48;
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (stall_hold == 0) begin
          out_ready <= ~out_ready;
          stall_hold <= $urandom_range(1, 6);
        end else begin
          stall_hold <= stall_hold - 1;
        end
      end
    endcase
  end

  function automatic in_word_t make_word(int f, int c, bit l);
    in_word_t w;
    w.freq = FREQ_W'(f);
    w.cum = CUM_W'(c);
    w.last_symbol = l;
    return w;
  endfunction

  // present one word at the falling edge, hold it until taken
  task automatic send_word(in_word_t w);
    @(negedge clk);
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and idle the sender, payload gets junk so it is never relied on
  task automatic idle_sender(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_word = in_word_t'($bits(in_word_t)'($urandom));
      repeat (n) @(posedge clk);
    end
  endtask

  // well-formed symbol from a legal table most of the time, junk otherwise
  function automatic in_word_t random_symbol(bit last);
    int f;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      // noise: zero or oversized frequency, any cum, any flag
      f = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(4097, 8191);
      return make_word(f, $urandom_range(0, 4095), last | 1'($urandom_range(0, 1)));
    end
    case ($urandom_range(0, 3))
      0: f = $urandom_range(1, 16);
      1: f = $urandom_range(17, 512);
      2: f = $urandom_range(513, 4096);
      default: f = 4096;
    endcase
    return make_word(f, $urandom_range(0, 4096 - f), last);
  endfunction

  initial begin
    int burst_left;
    int stream_left;
    in_word_t w;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed symbols, back to back
    send_word(make_word(1, 0, 1'b0));       // smallest freq, one renorm word from reset
    send_word(make_word(1, 4095, 1'b0));    // max cum, two renorm words
    send_word(make_word(1, 4095, 1'b1));    // renorm plus flush, five words
    send_word(make_word(4096, 0, 1'b0));    // largest legal freq
    send_word(make_word(4096, 4095, 1'b0));
    send_word(make_word(0, 123, 1'b0));     // zero freq leaves state alone
    send_word(make_word(0, 0, 1'b1));       // zero freq still flushes
    send_word(make_word(8191, 4095, 1'b0)); // oversized freq used as given
    send_word(make_word(4097, 1, 1'b1));
    send_word(make_word(2048, 2048, 1'b0));
    send_word(make_word(3, 4093, 1'b0));
    send_word(make_word(2, 1, 1'b0));
    send_word(make_word(7, 100, 1'b1));
    idle_sender(5);
    send_word(make_word(1, 0, 1'b1));       // single symbol stream
    send_word(make_word(4095, 1, 1'b0));
    send_word(make_word(5461, 2730, 1'b1)); // alternating bit patterns
    send_word(make_word(2730, 1365, 1'b1));

    // random streams in bursts
    burst_left = 0;
    stream_left = 0;
    for (int n = 0; n < RANDOM_SYMBOLS; n++) begin
      if (burst_left == 0) begin
        idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        burst_left = $urandom_range(1, 10);
      end
      if (stream_left == 0) stream_left = $urandom_range(1, 12);
      // hold off once until the block has delivered everything owed
      if (n == RANDOM_SYMBOLS / 2) begin
        idle_sender(1);
        while (sb.pending() != 0) @(posedge clk);
      end
      w = random_symbol(stream_left == 1);
      send_word(w);
      stream_left--;
      burst_left--;
    end
    idle_sender(1);

    // drain, then give trailing work time to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rse_pkg.sv
rtl/rse_ctrl.sv
rtl/rse_dpath.sv
rtl/rans_stream_encoder.sv
rtl/rse_checker.sv
sim/tb_rans_stream_encoder.sv
